FILE: design/ssp_pkg.sv
// ssp_pkg: shared constants for the sensor sector point filter.
// Register codes, reset values and field widths. No dependencies.
`timescale 1ns / 1ps

package ssp_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG    = 3'd5;

  localparam int ROT_W   = 48;
  localparam int TRANS_W = 60;
  localparam int LIM_W   = 40;
  localparam int TRIG_W  = 32;
  localparam int COEF_W  = 16;
  localparam int FRAC_W  = 14;   // Q2.14 rotation, Q2.14 trig

  localparam logic [ROT_W-1:0]   ROT_X_RST = 48'h0000_0000_4000;
  localparam logic [ROT_W-1:0]   ROT_Y_RST = 48'h0000_4000_0000;
  localparam logic [ROT_W-1:0]   ROT_Z_RST = 48'h4000_0000_0000;
  localparam logic [TRANS_W-1:0] TRANS_RST = '0;
  localparam logic [LIM_W-1:0]   RANGE_RST = 40'hC0_0000_0000;
  localparam logic [TRIG_W-1:0]  TRIG_RST  = 32'h0000_4000;

  // result count fields
  localparam int CNT_OUT_W = 21;

  // defaults for top-level parameters
  localparam int DEF_MAX_POINTS  = 1048576;
  localparam int DEF_COORD_WIDTH = 20;
  localparam int DEF_QUEUE_DEPTH = 8;

endpackage

FILE: design/ssp_front.sv
// ssp_front: config registers, point intake and the three-stage transform
// and range/sector classifier. Pushes classified points into the queue.
// Depends on ssp_pkg.
`timescale 1ns / 1ps

module ssp_front #(
  parameter int COORD_WIDTH = ssp_pkg::DEF_COORD_WIDTH,
  parameter int QUEUE_DEPTH = ssp_pkg::DEF_QUEUE_DEPTH,
  localparam int LVL_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int ENT_W      = 3 * COORD_WIDTH + 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [3*COORD_WIDTH-1:0]        in_coords,
  input  logic                            in_last,
  input  logic [LVL_W-1:0]                q_level,
  output logic                            push,
  output logic [ENT_W-1:0]                push_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int PW  = CW + ssp_pkg::COEF_W;        // one rotation product
  localparam int AW  = CW + 18;                     // row sum with translation
  localparam int QW  = CW + 4;                      // transformed coordinate
  localparam int SQW = 2 * QW;
  localparam int SXW = QW + ssp_pkg::COEF_W;
  localparam int SYW = QW + 1 + ssp_pkg::COEF_W;
  localparam int DW  = SYW + 1;
  localparam int RW  = (SQW + 2 > ssp_pkg::LIM_W) ? SQW + 2 : ssp_pkg::LIM_W;
  localparam int PLW = 3 * CW + 1;                  // coords and last flag

  // configuration registers
  logic [ssp_pkg::ROT_W-1:0]   rot_x, rot_y, rot_z;
  logic [ssp_pkg::TRANS_W-1:0] translation;
  logic [ssp_pkg::LIM_W-1:0]   range_lim;
  logic [ssp_pkg::TRIG_W-1:0]  trig;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_x       <= ssp_pkg::ROT_X_RST;
      rot_y       <= ssp_pkg::ROT_Y_RST;
      rot_z       <= ssp_pkg::ROT_Z_RST;
      translation <= ssp_pkg::TRANS_RST;
      range_lim   <= ssp_pkg::RANGE_RST;
      trig        <= ssp_pkg::TRIG_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ssp_pkg::REG_ROT_X: rot_x       <= cfg_data[ssp_pkg::ROT_W-1:0];
        ssp_pkg::REG_ROT_Y: rot_y       <= cfg_data[ssp_pkg::ROT_W-1:0];
        ssp_pkg::REG_ROT_Z: rot_z       <= cfg_data[ssp_pkg::ROT_W-1:0];
        ssp_pkg::REG_TRANS: translation <= cfg_data[ssp_pkg::TRANS_W-1:0];
        ssp_pkg::REG_RANGE: range_lim   <= cfg_data[ssp_pkg::LIM_W-1:0];
        ssp_pkg::REG_TRIG:  trig        <= cfg_data[ssp_pkg::TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // translation fields sit at CW-bit spacing; bits past the register read 0
  logic [3*CW+ssp_pkg::TRANS_W-1:0] trans_wide;
  logic [3*CW-1:0]                  trans_all;
  assign trans_wide = {{(3*CW){1'b0}}, translation};
  assign trans_all  = trans_wide[3*CW-1:0];

  // credit: ready only while queued plus in-flight points are below depth
  logic v1, v2, v3;
  logic [LVL_W:0] used;
  assign used     = (LVL_W+1)'(q_level) + (LVL_W+1)'(v1) + (LVL_W+1)'(v2)
                  + (LVL_W+1)'(v3);
  assign in_ready = used < (LVL_W+1)'(QUEUE_DEPTH);

  // stage 1: nine rotation products
  logic signed [ssp_pkg::COEF_W-1:0] coef [3][3];
  logic signed [CW-1:0]              pt   [3];
  logic signed [PW-1:0]              prod1 [3][3];
  logic signed [CW-1:0]              t1    [3];
  logic [PLW-1:0]                    pay1, pay2, pay3;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      coef[0][j] = rot_x[ssp_pkg::COEF_W*j +: ssp_pkg::COEF_W];
      coef[1][j] = rot_y[ssp_pkg::COEF_W*j +: ssp_pkg::COEF_W];
      coef[2][j] = rot_z[ssp_pkg::COEF_W*j +: ssp_pkg::COEF_W];
      pt[j]      = in_coords[CW*j +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid && in_ready;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod1[i][j] <= PW'(coef[i][j]) * PW'(pt[j]);
      end
      t1[i] <= trans_all[CW*i +: CW];
    end
    pay1 <= {in_last, in_coords};
  end

  // stage 2: row sums, translation, round half up to whole units
  logic signed [AW-1:0] rsum [3];
  logic signed [QW-1:0] q2   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i] = AW'(prod1[i][0]) + AW'(prod1[i][1]) + AW'(prod1[i][2])
              + (AW'(t1[i]) <<< ssp_pkg::FRAC_W)
              + AW'(1 <<< (ssp_pkg::FRAC_W - 1));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q2[i] <= QW'(rsum[i] >>> ssp_pkg::FRAC_W);
    end
    pay2 <= pay1;
  end

  // stage 3: squares and sector products
  logic signed [ssp_pkg::COEF_W-1:0] sin_v, cos_v;
  logic signed [QW:0]                ay;
  logic [SQW-1:0]                    sq3 [3];
  logic signed [SXW-1:0]             sx3;
  logic signed [SYW-1:0]             sy3;
  logic                              origin3;
  logic signed [SQW-1:0]             sq_c [3];

  assign sin_v = trig[ssp_pkg::COEF_W-1:0];
  assign cos_v = trig[2*ssp_pkg::COEF_W-1:ssp_pkg::COEF_W];
  assign ay    = q2[1][QW-1] ? -((QW+1)'(q2[1])) : (QW+1)'(q2[1]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_c[i] = SQW'(q2[i]) * SQW'(q2[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq3[i] <= sq_c[i];
    end
    sx3     <= SXW'(q2[0]) * SXW'(sin_v);
    sy3     <= SYW'(ay) * SYW'(cos_v);
    origin3 <= (q2[0] == '0) && (q2[1] == '0) && (q2[2] == '0);
    pay3    <= pay2;
  end

  // final compare feeds the queue directly
  logic [RW-1:0]        r2;
  logic signed [DW-1:0] sdiff;
  logic                 in_range, in_sector;

  assign r2        = RW'(sq3[0]) + RW'(sq3[1]) + RW'(sq3[2]);
  assign in_range  = r2 < RW'(range_lim);
  assign sdiff     = DW'(sx3) - DW'(sy3);
  assign in_sector = origin3 || (!sdiff[DW-1] && (sdiff != '0));

  assign push      = v3;
  assign push_data = {in_range && in_sector, pay3};

endmodule

FILE: design/ssp_fifo.sv
// ssp_fifo: small queue of classified points between front and back.
// Register-file storage, one push and one pop per cycle. Depends on ssp_pkg.
`timescale 1ns / 1ps

module ssp_fifo #(
  parameter int WIDTH = 3 * ssp_pkg::DEF_COORD_WIDTH + 2,
  parameter int DEPTH = ssp_pkg::DEF_QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int LVL_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty,
  output logic [LVL_W-1:0] level
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers wrap at DEPTH, so the depth need not be a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      level <= level + LVL_W'(push) - LVL_W'(pop);
    end
  end

  assign pop_data  = mem[rd_ptr];
  assign not_empty = level != '0;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> level != LVL_W'(DEPTH))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue pop while empty");

endmodule

FILE: design/ssp_back.sv
// ssp_back: pops classified points, keeps the saturating cloud counters and
// holds the result register toward the output stream. Depends on ssp_pkg.
`timescale 1ns / 1ps

module ssp_back #(
  parameter int MAX_POINTS  = ssp_pkg::DEF_MAX_POINTS,
  parameter int COORD_WIDTH = ssp_pkg::DEF_COORD_WIDTH,
  localparam int ENT_W      = 3 * COORD_WIDTH + 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_not_empty,
  input  logic [ENT_W-1:0]                 q_data,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_accepted,
  output logic                             out_last,
  output logic [3*COORD_WIDTH-1:0]         out_coords,
  output logic [ssp_pkg::CNT_OUT_W-1:0]    out_acc_total,
  output logic [ssp_pkg::CNT_OUT_W-1:0]    out_pt_total
);

  localparam int CW    = COORD_WIDTH;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int OW    = ssp_pkg::CNT_OUT_W;
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_POINTS);

  logic             e_acc, e_last;
  logic [CNT_W-1:0] acc_cnt, pt_cnt, acc_cnt_next, pt_cnt_next;
  logic [CNT_W+OW-1:0] acc_ext, pt_ext;

  assign e_acc  = q_data[3*CW+1];
  assign e_last = q_data[3*CW];
  assign pop    = q_not_empty && (!out_valid || out_ready);

  assign pt_cnt_next  = (pt_cnt == MaxCnt) ? pt_cnt : pt_cnt + CNT_W'(1);
  assign acc_cnt_next = (!e_acc || acc_cnt == MaxCnt) ? acc_cnt
                                                      : acc_cnt + CNT_W'(1);
  assign acc_ext = {{OW{1'b0}}, acc_cnt_next};
  assign pt_ext  = {{OW{1'b0}}, pt_cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc_cnt   <= '0;
      pt_cnt    <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        acc_cnt   <= e_last ? '0 : acc_cnt_next;
        pt_cnt    <= e_last ? '0 : pt_cnt_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_accepted  <= e_acc;
      out_last      <= e_last;
      out_coords    <= q_data[3*CW-1:0];
      out_acc_total <= e_last ? acc_ext[OW-1:0] : '0;
      out_pt_total  <= e_last ? pt_ext[OW-1:0] : '0;
    end
  end

  a_cnt_order: assert property (@(posedge clk) disable iff (rst)
    acc_cnt <= pt_cnt)
    else $error("accept count above point count");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    pop && e_last |=> acc_cnt == '0 && pt_cnt == '0)
    else $error("counters not cleared after last point");

  a_totals_only_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_acc_total == '0 && out_pt_total == '0)
    else $error("totals shown on a point that is not last");

endmodule

FILE: design/sensor_sector_point_filter.sv
// sensor_sector_point_filter: top level; front classifier, point queue and
// result stage. Depends on ssp_pkg, ssp_front, ssp_fifo, ssp_back.
`timescale 1ns / 1ps

// Filters a stream of 3-D points against another sensor's range and view
// sector. Each point is rotated (Q2.14) and translated, rounded half up,
// and accepted when its squared range is below range_limit_sq and
// x*sin - |y|*cos > 0 (a point landing on the origin passes the sector
// test). Every point returns one result that echoes the input coordinates
// with the accept flag in tuser; the result flagged with tlast also carries
// the saturating accepted and total counts, after which the counters clear.
// Throughput is one point per cycle while input tready stays high. An
// accepted point passes the three transform stages into the queue and
// moves on to the output register once that is free. Input tready drops
// when queue entries plus points in the three transform stages reach
// QUEUE_DEPTH, so a stalled output stops intake only once the queue fills.
// Configuration writes are always ready and must be made while no point is in flight.
module sensor_sector_point_filter #(
  parameter int MAX_POINTS  = ssp_pkg::DEF_MAX_POINTS,
  parameter int COORD_WIDTH = ssp_pkg::DEF_COORD_WIDTH,
  parameter int QUEUE_DEPTH = ssp_pkg::DEF_QUEUE_DEPTH,
  localparam int IN_DW  = ((3 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((3 * COORD_WIDTH + 2 * ssp_pkg::CNT_OUT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]  cfg_data,
  // point input
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_DW-1:0]                s_axis_tdata,  // point_x, point_y, point_z
  input  logic                            s_axis_tlast,  // last_point
  // result output
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_x, out_y, out_z, accepted_total, point_total
  output logic [OUT_DW-1:0]               m_axis_tdata,
  output logic                            m_axis_tuser,  // accepted
  output logic                            m_axis_tlast   // end_of_cloud
);

  localparam int CW    = COORD_WIDTH;
  localparam int ENT_W = 3 * CW + 2;
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  logic                          q_push, q_pop, q_not_empty;
  logic [ENT_W-1:0]              q_push_data, q_pop_data;
  logic [LVL_W-1:0]              q_level;
  logic [3*CW-1:0]               out_coords;
  logic [ssp_pkg::CNT_OUT_W-1:0] out_acc_total, out_pt_total;

  assign cfg_ready = 1'b1;

  ssp_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_coords (s_axis_tdata[3*CW-1:0]),
    .in_last   (s_axis_tlast),
    .q_level   (q_level),
    .push      (q_push),
    .push_data (q_push_data)
  );

  ssp_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_not_empty),
    .level     (q_level)
  );

  ssp_back #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_not_empty   (q_not_empty),
    .q_data        (q_pop_data),
    .pop           (q_pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_accepted  (m_axis_tuser),
    .out_last      (m_axis_tlast),
    .out_coords    (out_coords),
    .out_acc_total (out_acc_total),
    .out_pt_total  (out_pt_total)
  );

  assign m_axis_tdata = OUT_DW'({out_pt_total, out_acc_total, out_coords});

endmodule

FILE: tb/sensor_sector_point_filter_tb.sv
// sensor_sector_point_filter_tb: self-checking testbench for the point filter.
// Predicts accept flags and per-cloud counts in-line and checks each result.
// Depends on ssp_pkg and sensor_sector_point_filter.
`timescale 1ns / 1ps

module sensor_sector_point_filter_tb;

  localparam int COORD_W = ssp_pkg::DEF_COORD_WIDTH;
  localparam int CNT_W = ssp_pkg::CNT_OUT_W;
  localparam int CFG_DW = ssp_pkg::CFG_DATA_W;
  localparam int CFG_IW = ssp_pkg::CFG_IDX_W;
  localparam int COEF_BITS = ssp_pkg::COEF_W;
  localparam int IN_DW = ((3 * COORD_W + 7) / 8) * 8;
  localparam int OUT_DW = ((3 * COORD_W + 2 * CNT_W + 7) / 8) * 8;
  localparam int SAT_COUNT = ssp_pkg::DEF_MAX_POINTS;
  localparam int SETTLE_CYCLES = 16;  // transform stages + queue + output reg
  localparam logic [CFG_IW-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IW-1:0] REG_SPARE_7 = 3'd7;
  localparam logic [COORD_W-1:0] C_MAX = 20'h7FFFF;
  localparam logic [COORD_W-1:0] C_MIN = 20'h80000;

  typedef struct {
    logic               accepted;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               end_of_cloud;
    logic [CNT_W-1:0]   accepted_total;
    logic [CNT_W-1:0]   point_total;
  } point_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DW-1:0] s_axis_tdata = '0;  // point_x, point_y, point_z
  logic s_axis_tlast = 1'b0;            // last_point
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // out_x, out_y, out_z, accepted_total, point_total
  logic [OUT_DW-1:0] m_axis_tdata;
  logic m_axis_tuser;  // accepted
  logic m_axis_tlast;  // end_of_cloud

  // shadow of the block's registers and counters
  logic [ssp_pkg::ROT_W-1:0]   shadow_rot [3] =
      '{ssp_pkg::ROT_X_RST, ssp_pkg::ROT_Y_RST, ssp_pkg::ROT_Z_RST};
  logic [ssp_pkg::TRANS_W-1:0] shadow_trans = ssp_pkg::TRANS_RST;
  logic [ssp_pkg::LIM_W-1:0]   shadow_range = ssp_pkg::RANGE_RST;
  logic [ssp_pkg::TRIG_W-1:0]  shadow_trig = ssp_pkg::TRIG_RST;
  logic [CNT_W-1:0] cloud_accept_count = '0;
  logic [CNT_W-1:0] cloud_point_count = '0;

  point_result_t pending_point_results[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int points_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int clouds_closed = 0;
  int points_kept = 0;

  sensor_sector_point_filter DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Transform, then range and view-sector test; exact 64-bit arithmetic.
  function automatic logic sector_accepts(input logic [COORD_W-1:0] px, py, pz);
    longint p[3];
    longint q[3];
    longint sum, r2, s, c, ay;
    logic in_sector;
    int i, j;
    p[0] = longint'($signed(px));
    p[1] = longint'($signed(py));
    p[2] = longint'($signed(pz));
    for (i = 0; i < 3; i++) begin
      sum = longint'($signed(shadow_trans[COORD_W*i +: COORD_W]))
          * (longint'(1) << ssp_pkg::FRAC_W);
      for (j = 0; j < 3; j++)
        sum += longint'($signed(shadow_rot[i][COEF_BITS*j +: COEF_BITS])) * p[j];
      // round half up: floor((v + 2^13) / 2^14)
      q[i] = (sum + (longint'(1) << (ssp_pkg::FRAC_W - 1))) >>> ssp_pkg::FRAC_W;
    end
    r2 = q[0] * q[0] + q[1] * q[1] + q[2] * q[2];
    s = longint'($signed(shadow_trig[COEF_BITS-1:0]));
    c = longint'($signed(shadow_trig[2*COEF_BITS-1:COEF_BITS]));
    ay = (q[1] < 0) ? -q[1] : q[1];
    if (q[0] == 0 && q[1] == 0 && q[2] == 0) in_sector = 1'b1;
    else in_sector = (q[0] * s - ay * c) > 0;
    return (r2 < longint'(shadow_range)) && in_sector;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(3))
      0: return COORD_W'($urandom);
      1: return COORD_W'(int'($urandom_range(2000)) - 1000);
      2: return COORD_W'(int'($urandom_range(131072)) - 65536);
      default: begin
        case ($urandom_range(4))
          0: return C_MAX;
          1: return C_MIN;
          2: return '0;
          3: return '1;
          default: return COORD_W'(1);
        endcase
      end
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] pack_row(input int a, input int b, input int c);
    return CFG_DW'({COEF_BITS'(c), COEF_BITS'(b), COEF_BITS'(a)});
  endfunction

  function automatic logic [CFG_DW-1:0] pack_trans(input int tx, input int ty, input int tz);
    return CFG_DW'({COORD_W'(tz), COORD_W'(ty), COORD_W'(tx)});
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("MISMATCH @%0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_field(input string what, input longint got, input longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    point_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_point_results.size() == 0) begin
        report_mismatch("unexpected result transaction, x", m_axis_tdata[COORD_W-1:0], 0);
      end else begin
        want = pending_point_results.pop_front();
        results_checked++;
        check_field("accepted", m_axis_tuser, want.accepted);
        check_field("out_x", m_axis_tdata[0 +: COORD_W], want.x);
        check_field("out_y", m_axis_tdata[COORD_W +: COORD_W], want.y);
        check_field("out_z", m_axis_tdata[2*COORD_W +: COORD_W], want.z);
        check_field("end_of_cloud", m_axis_tlast, want.end_of_cloud);
        check_field("accepted_total", m_axis_tdata[3*COORD_W +: CNT_W],
                    want.accepted_total);
        check_field("point_total", m_axis_tdata[3*COORD_W+CNT_W +: CNT_W],
                    want.point_total);
      end
    end
  end

  // Leaves tvalid high after the transaction so back-to-back points stream.
  task automatic send_point(input logic [COORD_W-1:0] x, y, z, input logic last);
    point_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_DW - 3 * COORD_W){1'b0}}, z, y, x};
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    points_sent++;
    res.accepted = sector_accepts(x, y, z);
    res.x = x;
    res.y = y;
    res.z = z;
    res.end_of_cloud = last;
    if (cloud_point_count < SAT_COUNT) cloud_point_count++;
    if (res.accepted && cloud_accept_count < SAT_COUNT) cloud_accept_count++;
    if (res.accepted) points_kept++;
    if (last) begin
      res.accepted_total = cloud_accept_count;
      res.point_total = cloud_point_count;
      cloud_accept_count = '0;
      cloud_point_count = '0;
      clouds_closed++;
    end else begin
      res.accepted_total = '0;
      res.point_total = '0;
    end
    pending_point_results.insert(pending_point_results.size(), res);
  endtask

  task automatic wait_results_drained(input int extra_cycles);
    s_axis_tvalid <= 1'b0;
    while (pending_point_results.size() != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    wait_results_drained(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      ssp_pkg::REG_ROT_X: shadow_rot[0] = data[ssp_pkg::ROT_W-1:0];
      ssp_pkg::REG_ROT_Y: shadow_rot[1] = data[ssp_pkg::ROT_W-1:0];
      ssp_pkg::REG_ROT_Z: shadow_rot[2] = data[ssp_pkg::ROT_W-1:0];
      ssp_pkg::REG_TRANS: shadow_trans = data[ssp_pkg::TRANS_W-1:0];
      ssp_pkg::REG_RANGE: shadow_range = data[ssp_pkg::LIM_W-1:0];
      ssp_pkg::REG_TRIG:  shadow_trig = data[ssp_pkg::TRIG_W-1:0];
      default: ;  // spare indexes are dropped by the block
    endcase
  endtask

  task automatic load_setting(input logic [CFG_DW-1:0] rx, ry, rz, tr, rg, tg);
    write_reg(ssp_pkg::REG_ROT_X, rx);
    write_reg(ssp_pkg::REG_ROT_Y, ry);
    write_reg(ssp_pkg::REG_ROT_Z, rz);
    write_reg(ssp_pkg::REG_TRANS, tr);
    write_reg(ssp_pkg::REG_RANGE, rg);
    write_reg(ssp_pkg::REG_TRIG, tg);
  endtask

  // Origin and corner points first, then random points; closes the cloud.
  task automatic send_cloud(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      case (k)
        0: send_point('0, '0, '0, k == n - 1);
        1: send_point(C_MAX, C_MIN, C_MAX, k == n - 1);
        2: send_point(C_MIN, C_MAX, C_MIN, k == n - 1);
        default: send_point(rand_coord(), rand_coord(), rand_coord(), k == n - 1);
      endcase
    end
  endtask

  // Rotation about z plus a plausible offset, range and half view angle.
  task automatic load_sensor_pose();
    int cosv[7] = '{16384, 14189, 11585, 8192, 0, -11585, -16384};
    int sinv[7] = '{0, 8192, 11585, 14189, 16384, 11585, 0};
    int a, h;
    longint r;
    a = $urandom_range(6);
    h = $urandom_range(6);
    r = $urandom_range(900000, 1000);
    load_setting(pack_row(cosv[a], -sinv[a], 0), pack_row(sinv[a], cosv[a], 0),
                 pack_row(0, 0, 16384),
                 pack_trans(int'($urandom_range(131072)) - 65536,
                            int'($urandom_range(131072)) - 65536,
                            int'($urandom_range(131072)) - 65536),
                 CFG_DW'(r * r), CFG_DW'({COEF_BITS'(cosv[h]), COEF_BITS'(sinv[h])}));
  endtask

  // Reset pose: identity, no offset, sector is x > 0.
  task automatic test_directed_points();
    send_point('0, '0, '0, 1'b0);                 // origin passes the sector test
    send_point(COORD_W'(1), '0, '0, 1'b0);
    send_point('1, '0, '0, 1'b0);
    send_point('0, COORD_W'(1), '0, 1'b0);        // on the sector edge: rejected
    send_point('0, '0, C_MIN, 1'b1);              // on z axis, not the origin
    send_point(C_MAX, C_MAX, C_MAX, 1'b1);        // just inside range
    send_point(C_MIN, C_MIN, C_MIN, 1'b0);        // exactly at the limit
    send_point(C_MAX, C_MIN, C_MIN, 1'b0);
    send_point(C_MAX, '0, '0, 1'b0);
    send_point(20'h55555, 20'hAAAAA, 20'h55555, 1'b0);
    send_point(20'hAAAAA, 20'h55555, 20'hAAAAA, 1'b1);
    send_point(COORD_W'(1000), COORD_W'(-999), COORD_W'(3), 1'b1);
  endtask

  task automatic test_register_extremes();
    // 90 degree yaw, offset, 30 degree half angle
    load_setting(pack_row(0, -16384, 0), pack_row(16384, 0, 0), pack_row(0, 0, 16384),
                 pack_trans(2560, -1280, 77), CFG_DW'(40'd40000000000),
                 CFG_DW'(32'h376D_2000));
    send_cloud(20);
    // largest coefficients, high register bits set to show they are dropped
    load_setting(60'hFFF_7FFF_7FFF_7FFF, 60'hFFF_7FFF_7FFF_7FFF, 60'hFFF_7FFF_7FFF_7FFF,
                 pack_trans(524287, -524288, 524287), {20'hFFFFF, 40'hFF_FFFF_FFFF},
                 {28'hFFF_FFFF, 16'h7FFF, 16'h8000});
    send_cloud(20);
    // most negative coefficients, zero range rejects everything
    load_setting(CFG_DW'(48'h8000_8000_8000), CFG_DW'(48'h8000_8000_8000),
                 CFG_DW'(48'h8000_8000_8000), pack_trans(-524288, -524288, -524288),
                 '0, CFG_DW'({16'h8000, 16'h7FFF}));
    send_cloud(15);
    // zero trig: only the origin is inside the sector; spare indexes change nothing
    load_setting(pack_row(16384, 0, 0), pack_row(0, 16384, 0), pack_row(0, 0, 16384),
                 '0, CFG_DW'(40'hFF_FFFF_FFFF), '0);
    write_reg(REG_SPARE_6, CFG_DW'({$urandom, $urandom}));
    write_reg(REG_SPARE_7, '1);
    send_cloud(15);
  endtask

  task automatic test_random_settings();
    int k;
    for (k = 0; k < 3; k++) begin
      load_setting(CFG_DW'({$urandom, $urandom}), CFG_DW'({$urandom, $urandom}),
                   CFG_DW'({$urandom, $urandom}), CFG_DW'({$urandom, $urandom}),
                   CFG_DW'({$urandom, $urandom}), CFG_DW'({$urandom, $urandom}));
      send_cloud(15);
    end
  endtask

  task automatic test_random_clouds(input int n, input int send_pct, input int recv_pct);
    int sent, len, k;
    logic paused;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    load_sensor_pose();
    sent = 0;
    paused = 1'b0;
    while (sent < n) begin
      len = $urandom_range(40, 1);
      for (k = 0; k < len; k++) begin
        send_point(rand_coord(), rand_coord(), rand_coord(), k == len - 1);
        sent++;
      end
      if (!paused && sent >= n / 2) begin
        wait_results_drained(0);  // sender holds off until every result is back
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_points();
    test_register_extremes();
    test_random_settings();
    test_random_clouds(140, 6, 88);
    test_random_clouds(140, 88, 6);
    test_random_clouds(140, 0, 0);
    wait_results_drained(SETTLE_CYCLES);
    $display("Covered %0d points in %0d clouds (%0d kept), %0d register writes,",
             points_sent, clouds_closed, points_kept, reg_writes);
    $display("directed corners, extreme and random poses, stalls both ways; %0d checked",
             results_checked);
    if (mismatch_count == 0 && pending_point_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", pending_point_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sensor_sector_point_filter.f
design/ssp_pkg.sv
design/ssp_front.sv
design/ssp_fifo.sv
design/ssp_back.sv
design/sensor_sector_point_filter.sv
tb/sensor_sector_point_filter_tb.sv
